// File: rtl/core/lgs_pkg.sv
// Shared constants, types and a helper function for the Life generation stream block.
package lgs_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int DIM_W       = 11;
   localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W       = $clog2(MAX_HEIGHT) + 1;
   localparam int CMP_A       = (COL_W + 1 > ROW_W + 1) ? COL_W + 1 : ROW_W + 1;
   localparam int CMP_W       = (CMP_A > DIM_W) ? CMP_A : DIM_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CSR_IDX_W   = 1;
   localparam int WIN_W       = 9;
   localparam int NCOUNT_W    = 4;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type REG_FRAME_WIDTH  = 1'b0;
   localparam csr_index_type REG_FRAME_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(64);
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(64);

   localparam logic [NCOUNT_W-1:0] BIRTH_COUNT   = NCOUNT_W'(3);
   localparam logic [NCOUNT_W-1:0] SURVIVE_COUNT = NCOUNT_W'(2);

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             cell_dead;
      logic             emit;
      logic             first_col;
      logic             last_col;
      logic             first_row;
      logic             last_row;
      logic             frame_end;
   } lgs_item_type;

   function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                  input int maxv);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(value);
      if (value == '0) begin
         return CMP_W'(1);
      end
      if (ext > CMP_W'(maxv)) begin
         return CMP_W'(maxv);
      end
      return ext;
   endfunction

endpackage

// File: rtl/core/lgs_front.sv
// Front end: configuration registers, raster position counters and request classification.
module lgs_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic                        req_cell_dead,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  lgs_pkg::csr_index_type      csr_index,
   input  logic [lgs_pkg::DIM_W-1:0]   csr_data,
   output logic                        push_valid,
   output lgs_pkg::lgs_item_type       push_item,
   input  logic                        queue_full
);

   logic [lgs_pkg::DIM_W-1:0] frame_width_ff, frame_width_in;
   logic [lgs_pkg::DIM_W-1:0] frame_height_ff, frame_height_in;
   logic [lgs_pkg::COL_W-1:0] in_col_ff, in_col_in;
   logic [lgs_pkg::ROW_W-1:0] in_row_ff, in_row_in;
   logic [lgs_pkg::COL_W-1:0] out_col_ff, out_col_in;
   logic [lgs_pkg::ROW_W-1:0] out_row_ff, out_row_in;

   logic [lgs_pkg::CMP_W-1:0] width_used;
   logic [lgs_pkg::CMP_W-1:0] height_used;
   logic [lgs_pkg::CMP_W-1:0] in_col_inc;
   logic [lgs_pkg::CMP_W-1:0] in_row_ext;
   logic [lgs_pkg::CMP_W-1:0] out_col_inc;
   logic [lgs_pkg::CMP_W-1:0] out_row_inc;
   logic                      accept;
   logic                      idle_flush;
   logic                      emit;
   logic                      row_wrap;
   logic                      last_col;
   logic                      last_row;
   logic                      frame_end;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;

   always_comb begin
      width_used  = lgs_pkg::clamp_dim(frame_width_ff, lgs_pkg::MAX_WIDTH);
      height_used = lgs_pkg::clamp_dim(frame_height_ff, lgs_pkg::MAX_HEIGHT);
      in_col_inc  = lgs_pkg::CMP_W'(in_col_ff) + lgs_pkg::CMP_W'(1);
      in_row_ext  = lgs_pkg::CMP_W'(in_row_ff);
      out_col_inc = lgs_pkg::CMP_W'(out_col_ff) + lgs_pkg::CMP_W'(1);
      out_row_inc = lgs_pkg::CMP_W'(out_row_ff) + lgs_pkg::CMP_W'(1);
      accept      = req_valid && !queue_full;
      idle_flush  = req_func && (in_row_ff == '0) && (in_col_ff == '0);
      emit        = (in_row_ext >= lgs_pkg::CMP_W'(2)) ||
                    ((in_row_ext == lgs_pkg::CMP_W'(1)) && (in_col_ff != '0));
      row_wrap    = in_col_inc >= width_used;
      last_col    = out_col_inc >= width_used;
      last_row    = out_row_inc >= height_used;
      frame_end   = emit && last_col && last_row;
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lgs_pkg::REG_FRAME_WIDTH: begin
               frame_width_in = csr_data;
            end
            lgs_pkg::REG_FRAME_HEIGHT: begin
               frame_height_in = csr_data;
            end
         endcase
      end
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept && !idle_flush) begin
         if (row_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + lgs_pkg::ROW_W'(1);
         end else begin
            in_col_in = lgs_pkg::COL_W'(in_col_inc);
         end
         if (emit) begin
            if (frame_end) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (last_col) begin
               out_col_in = '0;
               out_row_in = out_row_ff + lgs_pkg::ROW_W'(1);
            end else begin
               out_col_in = lgs_pkg::COL_W'(out_col_inc);
            end
         end
      end
   end

   always_comb begin
      push_valid           = accept && !idle_flush;
      push_item.col        = in_col_ff;
      push_item.cell_dead  = req_func || (in_row_ext >= height_used) || req_cell_dead;
      push_item.emit       = emit;
      push_item.first_col  = out_col_ff == '0;
      push_item.last_col   = last_col;
      push_item.first_row  = out_row_ff == '0;
      push_item.last_row   = last_row;
      push_item.frame_end  = frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= lgs_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= lgs_pkg::FRAME_HEIGHT_RESET;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         in_col_ff       <= in_col_in;
         in_row_ff       <= in_row_in;
         out_col_ff      <= out_col_in;
         out_row_ff      <= out_row_in;
      end
   end

endmodule

// File: rtl/core/lgs_queue.sv
// Short queue of classified requests between the front end and the back end.
module lgs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  lgs_pkg::lgs_item_type push_item,
   output logic                  queue_full,
   output logic                  pop_valid,
   output lgs_pkg::lgs_item_type pop_item,
   input  logic                  pop_ready
);

   lgs_pkg::lgs_item_type        slots_ff [lgs_pkg::QUEUE_DEPTH];
   logic [lgs_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [lgs_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [lgs_pkg::QPTR_W:0]     count_ff, count_in;
   logic                         do_pop;

   always_comb begin
      queue_full = count_ff == (lgs_pkg::QPTR_W + 1)'(lgs_pkg::QUEUE_DEPTH);
      pop_valid  = count_ff != '0;
      pop_item   = slots_ff[rd_ptr_ff];
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = push_valid ? wr_ptr_ff + lgs_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + lgs_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + (lgs_pkg::QPTR_W + 1)'(1);
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - (lgs_pkg::QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/lgs_back.sv
// Back end: line store, 3x3 window, neighbor count and the registered result stage.
module lgs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   input  lgs_pkg::lgs_item_type pop_item,
   output logic                  pop_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_next_dead,
   output logic                  rsp_last_of_frame
);

   logic [1:0]                   line_mem_ff [lgs_pkg::MAX_WIDTH];
   logic [1:0]                   rd_data_ff;
   logic                         fwd_ff, fwd_in;
   logic [1:0]                   fwd_data_ff;
   lgs_pkg::lgs_item_type        b_item_ff;
   logic                         b_valid_ff, b_valid_in;
   logic [lgs_pkg::WIN_W-1:0]    window_ff, window_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_next_dead_ff;
   logic                         rsp_last_ff;

   logic                         b_commit;
   logic                         a_advance;
   logic [1:0]                   line_rd;
   logic [1:0]                   line_wr;
   logic [lgs_pkg::NCOUNT_W-1:0] alive_count;
   logic                         center_alive;
   logic                         next_alive;
   logic                         pos_ok;

   always_comb begin
      b_commit   = b_valid_ff && (!b_item_ff.emit || !rsp_valid_ff || !rsp_stall);
      pop_ready  = !b_valid_ff || b_commit;
      a_advance  = pop_valid && pop_ready;
      b_valid_in = a_advance || (b_valid_ff && !b_commit);
      fwd_in     = b_commit && (b_item_ff.col == pop_item.col);
      line_rd    = fwd_ff ? fwd_data_ff : rd_data_ff;
      line_wr    = {b_item_ff.cell_dead, line_rd[1]};
      window_in  = {b_item_ff.cell_dead, line_rd[1], line_rd[0], window_ff[8:3]};
   end

   always_comb begin
      alive_count = '0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            pos_ok = !((c == 0) && b_item_ff.first_col) &&
                     !((c == 2) && b_item_ff.last_col) &&
                     !((r == 0) && b_item_ff.first_row) &&
                     !((r == 2) && b_item_ff.last_row);
            if (!((c == 1) && (r == 1)) && pos_ok && !window_in[c * 3 + r]) begin
               alive_count = alive_count + lgs_pkg::NCOUNT_W'(1);
            end
         end
      end
      center_alive = !window_in[4];
      if (center_alive) begin
         next_alive = (alive_count == lgs_pkg::SURVIVE_COUNT) ||
                      (alive_count == lgs_pkg::BIRTH_COUNT);
      end else begin
         next_alive = alive_count == lgs_pkg::BIRTH_COUNT;
      end
      if (b_commit && b_item_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_commit) begin
         line_mem_ff[b_item_ff.col] <= line_wr;
      end
      if (a_advance) begin
         rd_data_ff <= line_mem_ff[pop_item.col];
      end
   end

   always_ff @(posedge clock) begin
      if (a_advance) begin
         b_item_ff   <= pop_item;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= line_wr;
      end
      if (b_commit && b_item_ff.emit) begin
         rsp_next_dead_ff <= !next_alive;
         rsp_last_ff      <= b_item_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         window_ff    <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (b_commit) begin
            window_ff <= window_in;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_dead     = rsp_next_dead_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

// File: rtl/core/life_generation_stream.sv
// Top level of the Life generation stream block: front end, request queue and back end.
// Throughput is one request per cycle unless a stall holds it; each request passes
// the front end, the queue and the line store read before its result register loads.
// A cell's result follows frame_width + 1 requests after the cell itself.
// Synchronous active-high reset clears counters, queue, window and result valid at once;
// the line store needs no clearing and the block accepts requests right after reset.
module life_generation_stream (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic                        req_cell_dead,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_next_dead,
   output logic                        rsp_last_of_frame,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  lgs_pkg::csr_index_type      csr_index,
   input  logic [lgs_pkg::DIM_W-1:0]   csr_data
);

   logic                  push_valid;
   lgs_pkg::lgs_item_type push_item;
   logic                  queue_full;
   logic                  pop_valid;
   lgs_pkg::lgs_item_type pop_item;
   logic                  pop_ready;

   lgs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_cell_dead (req_cell_dead),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .push_valid    (push_valid),
      .push_item     (push_item),
      .queue_full    (queue_full)
   );

   lgs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .queue_full (queue_full),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   lgs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_item          (pop_item),
      .pop_ready         (pop_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_next_dead     (rsp_next_dead),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
